FILE: hw/rtl/pkst_pkg.sv
// Shared constants and types for the pair-key status hash table.
package pkst_pkg;

    localparam int unsigned BucketsDefault  = 1024;
    localparam int unsigned CapacityDefault = 1024;

    localparam logic [31:0] HashMulX = 32'd12841;
    localparam logic [31:0] HashMulY = 32'd89189;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_LOCKED = 2'd1,
        ERR_FULL   = 2'd2
    } err_code_t;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

endpackage

FILE: hw/rtl/pkst_req_if.sv
// Request channel interface: valid/ready plus request payload.
interface pkst_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [1:0]  new_status;

    modport source (output valid, req_type, key_x, key_y, new_status, input ready);
    modport sink   (input valid, req_type, key_x, key_y, new_status, output ready);
endinterface

FILE: hw/rtl/pkst_rsp_if.sv
// Response channel interface: valid/ready plus response payload.
interface pkst_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status_out;
    logic       found;
    logic [1:0] error_code;

    modport source (output valid, status_out, found, error_code, input ready);
    modport sink   (input valid, status_out, found, error_code, output ready);
endinterface

FILE: hw/rtl/pkst_hash.sv
// Bucket hash: products registered, then summed and masked.
module pkst_hash #(
    parameter int unsigned BUCKETS = pkst_pkg::BucketsDefault,
    parameter int unsigned BW      = 10
) (
    input  logic          clk,
    input  logic [31:0]   key_x,
    input  logic [31:0]   key_y,
    output logic [BW-1:0] bucket
);
    localparam logic [31:0] Mask = 32'(BUCKETS - 1);

    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [31:0] sum;

    always_ff @(posedge clk)
    begin
        px_reg <= key_x * pkst_pkg::HashMulX;
        py_reg <= key_y * pkst_pkg::HashMulY;
    end

    assign sum    = (px_reg + py_reg) & Mask;
    assign bucket = sum[BW-1:0];
endmodule

FILE: hw/rtl/pkst_entry_mem.sv
// Entry store: key pair, status and chain link, one read and one write port.
module pkst_entry_mem #(
    parameter int unsigned CAPACITY = pkst_pkg::CapacityDefault,
    parameter int unsigned EW       = 10,
    parameter int unsigned LW       = 11
) (
    input  logic          clk,
    input  logic [EW-1:0] rd_addr,
    output logic [31:0]   rd_key_x,
    output logic [31:0]   rd_key_y,
    output logic [1:0]    rd_state,
    output logic [LW-1:0] rd_link,
    input  logic          wr_en,
    input  logic          wr_full,
    input  logic [EW-1:0] wr_addr,
    input  logic [31:0]   wr_key_x,
    input  logic [31:0]   wr_key_y,
    input  logic [1:0]    wr_state,
    input  logic [LW-1:0] wr_link
);
    typedef struct packed {
        logic [31:0]   kx;
        logic [31:0]   ky;
        logic [LW-1:0] link;
    } key_rec_t;

    key_rec_t   key_mem [CAPACITY];
    logic [1:0] st_mem  [CAPACITY];
    key_rec_t   key_rd_reg;
    logic [1:0] st_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_full)
        begin
            key_mem[wr_addr] <= '{kx: wr_key_x, ky: wr_key_y, link: wr_link};
        end
        if (wr_en)
        begin
            st_mem[wr_addr] <= wr_state;
        end
        key_rd_reg <= key_mem[rd_addr];
        st_rd_reg  <= st_mem[rd_addr];
    end

    assign rd_key_x = key_rd_reg.kx;
    assign rd_key_y = key_rd_reg.ky;
    assign rd_link  = key_rd_reg.link;
    assign rd_state = st_rd_reg;
endmodule

FILE: hw/rtl/pair_key_status_hash_table_core.sv
// Flow: each request is hashed, its bucket head read, then its chain walked entry by entry;
// the walk stops at the chain end or at the first entry whose key pair matches.
// One request is handled at a time; the chain is walked one link per read through the
// single read port of the entry store.
// Reset: control state and entry count clear at once; then a clearing pass writes
// every bucket head to empty, during which no request is taken.
module pair_key_status_hash_table_core #(
    parameter int unsigned BUCKETS  = pkst_pkg::BucketsDefault,
    parameter int unsigned CAPACITY = pkst_pkg::CapacityDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    pkst_req_if.sink     req,
    pkst_rsp_if.source   rsp
);
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned EW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] CapVal = LW'(CAPACITY);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HEAD_RD, S_HEAD_WT, S_ENT_WT, S_ENT_CMP,
        S_UPDATE, S_RESP
    } state_t;

    state_t        state_reg;
    logic [BW-1:0] clr_reg;
    logic          lock_reg;
    logic [LW-1:0] count_reg;
    logic          type_reg;
    logic [31:0]   kx_reg;
    logic [31:0]   ky_reg;
    logic [1:0]    ns_reg;
    logic [BW-1:0] bkt_reg;
    logic [LW-1:0] head_reg;
    logic [LW-1:0] ptr_reg;
    logic [LW-1:0] steps_reg;
    logic          hit_reg;
    logic [1:0]    st_out_reg;
    logic          found_reg;
    logic [1:0]    err_reg;
    logic          rsp_valid_reg;

    logic [LW-1:0] head_mem [BUCKETS];
    logic [LW-1:0] head_rd_reg;
    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [LW-1:0] head_wd;

    logic [BW-1:0] bucket;
    logic [EW-1:0] ent_rd_addr;
    logic [31:0]   e_kx, e_ky;
    logic [1:0]    e_st;
    logic [LW-1:0] e_link;
    logic          ent_we, ent_full;
    logic [EW-1:0] ent_wa;
    logic [LW-1:0] ptr_nxt;
    logic [LW-1:0] ptr_m1;

    pkst_hash #(.BUCKETS(BUCKETS), .BW(BW)) u_hash (
        .clk(clk), .key_x(kx_reg), .key_y(ky_reg), .bucket(bucket)
    );

    // Address the next chain entry while stepping, so its data is ready for the compare
    assign ptr_nxt     = (state_reg == S_ENT_WT) ?
                         ((steps_reg == '0 && !hit_reg) ? head_rd_reg : e_link) : ptr_reg;
    assign ptr_m1      = ptr_nxt - LW'(1);
    assign ent_rd_addr = ptr_m1[EW-1:0];

    pkst_entry_mem #(.CAPACITY(CAPACITY), .EW(EW), .LW(LW)) u_ent (
        .clk(clk), .rd_addr(ent_rd_addr),
        .rd_key_x(e_kx), .rd_key_y(e_ky), .rd_state(e_st), .rd_link(e_link),
        .wr_en(ent_we), .wr_full(ent_full), .wr_addr(ent_wa),
        .wr_key_x(kx_reg), .wr_key_y(ky_reg), .wr_state(ns_reg), .wr_link(head_reg)
    );

    // Bucket head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd_reg <= head_mem[bkt_reg];
    end

    logic new_ok;
    assign new_ok = (state_reg == S_UPDATE) && type_reg && !hit_reg && (count_reg < CapVal);

    always_comb
    begin
        head_we = 1'b0;
        head_wa = bkt_reg;
        head_wd = count_reg + LW'(1);
        if (state_reg == S_CLEAR)
        begin
            head_we = 1'b1;
            head_wa = clr_reg;
            head_wd = '0;
        end
        else if (new_ok)
        begin
            head_we = 1'b1;
        end
    end

    logic upd_ok;
    assign upd_ok   = (state_reg == S_UPDATE) && type_reg && hit_reg &&
                      !(lock_reg && (st_out_reg != ns_reg));
    assign ent_we   = new_ok || upd_ok;
    assign ent_full = new_ok;
    assign ent_wa   = new_ok ? count_reg[EW-1:0] : ent_rd_addr;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status_out = st_out_reg;
    assign rsp.found      = found_reg;
    assign rsp.error_code = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            lock_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lock_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + BW'(1);
                    if (clr_reg == BW'(BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        type_reg  <= req.req_type;
                        kx_reg    <= req.key_x;
                        ky_reg    <= req.key_y;
                        ns_reg    <= req.new_status;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    state_reg <= S_HEAD_RD;
                end
                S_HEAD_RD:
                begin
                    bkt_reg   <= bucket;
                    state_reg <= S_HEAD_WT;
                end
                S_HEAD_WT:
                begin
                    // head_rd_reg valid next cycle; use it in S_ENT_WT entry
                    state_reg <= S_ENT_WT;
                    steps_reg <= '0;
                    hit_reg   <= 1'b0;
                    ptr_reg   <= '0;
                end
                S_ENT_WT:
                begin
                    if (steps_reg == '0 && !hit_reg)
                    begin
                        head_reg <= head_rd_reg;
                    end
                    ptr_reg <= ptr_nxt;
                    // Advance: pointer now addresses next entry; check for chain end
                    if (ptr_nxt == '0 || ptr_nxt > CapVal || steps_reg >= CapVal)
                    begin
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        state_reg <= S_ENT_CMP;
                    end
                end
                S_ENT_CMP:
                begin
                    // entry read on the way in; data arrives now
                    if (e_kx == kx_reg && e_ky == ky_reg)
                    begin
                        st_out_reg <= e_st;
                        hit_reg    <= 1'b1;
                        state_reg  <= S_UPDATE;
                    end
                    else
                    begin
                        hit_reg   <= 1'b0;
                        steps_reg <= steps_reg + LW'(1);
                        state_reg <= S_ENT_WT;
                    end
                end
                S_UPDATE:
                begin
                    found_reg     <= hit_reg;
                    state_reg     <= S_RESP;
                    rsp_valid_reg <= 1'b1;
                    if (!type_reg)
                    begin
                        st_out_reg <= hit_reg ? st_out_reg : 2'd0;
                        err_reg    <= pkst_pkg::ERR_OK;
                    end
                    else
                    begin
                        st_out_reg <= 2'd0;
                        if (hit_reg)
                        begin
                            err_reg <= (lock_reg && (st_out_reg != ns_reg)) ?
                                       pkst_pkg::ERR_LOCKED : pkst_pkg::ERR_OK;
                        end
                        else if (count_reg >= CapVal)
                        begin
                            err_reg <= pkst_pkg::ERR_FULL;
                        end
                        else
                        begin
                            err_reg   <= pkst_pkg::ERR_OK;
                            count_reg <= count_reg + LW'(1);
                        end
                    end
                end
                S_RESP:
                begin
                    if (rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
